/* design/cjm_pkg.sv */
// ----------------------------------------------------------------------------
// cjm_pkg
// shared types and constants of the card job machine executor
// ----------------------------------------------------------------------------
package cjm_pkg;

    localparam int MEM_WORDS_DEF  = 100;
    localparam int CARD_WORDS_DEF = 10;

    localparam logic [31:0] SPACE_WORD = 32'h2020_2020;

    typedef enum logic [2:0] {
        OP_NEW_JOB   = 3'd0,
        OP_PROG_BYTE = 3'd1,
        OP_PROG_END  = 3'd2,
        OP_DATA_BYTE = 3'd3,
        OP_DATA_END  = 3'd4,
        OP_STEP      = 3'd5
    } op_t;

    typedef enum logic [2:0] {
        ST_OK     = 3'd0,
        ST_WAIT   = 3'd1,
        ST_WORD   = 3'd2,
        ST_HALT   = 3'd3,
        ST_ADDR   = 3'd4,
        ST_REFUSE = 3'd5
    } status_t;

    typedef enum logic [1:0] {
        MODE_LOADING = 2'd0,
        MODE_RUNNING = 2'd1,
        MODE_WAITING = 2'd2,
        MODE_HALTED  = 2'd3
    } mode_t;

    localparam logic [7:0] CH_LF   = 8'h0A;
    localparam logic [7:0] CH_CR   = 8'h0D;
    localparam logic [7:0] CH_ZERO = 8'h30;
    localparam logic [7:0] CH_G    = 8'h47;
    localparam logic [7:0] CH_D    = 8'h44;
    localparam logic [7:0] CH_P    = 8'h50;
    localparam logic [7:0] CH_H    = 8'h48;
    localparam logic [7:0] CH_L    = 8'h4C;
    localparam logic [7:0] CH_S    = 8'h53;
    localparam logic [7:0] CH_C    = 8'h43;
    localparam logic [7:0] CH_R    = 8'h52;
    localparam logic [7:0] CH_B    = 8'h42;
    localparam logic [7:0] CH_T    = 8'h54;

    typedef struct packed {
        logic [2:0] operation;
        logic [7:0] byte_in;
    } cjm_req_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [31:0] out_word;
        logic        last;
        logic [6:0]  counter_now;
        logic        compare_now;
    } cjm_rsp_t;

    // memory access request from the sequencer
    typedef struct packed {
        logic        rd;
        logic        wr;
        logic [6:0]  addr;
        logic [31:0] wdata;
    } cjm_mem_t;

endpackage

/* design/cjm_if.sv */
// ----------------------------------------------------------------------------
// cjm_req_if / cjm_rsp_if
// valid/ready channels of the card job machine executor
// ----------------------------------------------------------------------------
interface cjm_req_if;
    import cjm_pkg::*;
    logic     valid;
    logic     ready;
    cjm_req_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface cjm_rsp_if;
    import cjm_pkg::*;
    logic     valid;
    logic     ready;
    cjm_rsp_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

/* design/card_job_machine_executor.sv */
// ----------------------------------------------------------------------------
// card_job_machine_executor
// card driven teaching machine with a one-port word store
// ----------------------------------------------------------------------------
// Each request takes one pass through the single store port. A stored card
// byte is read when taken and written back in S_BYTE. Dropped bytes, control-only
// requests and steps that end before the fetch are answered from S_IDLE. Other
// steps decode in S_DEC and answer from S_OUT, LR and CR via S_OPND. PD reads
// each output word through S_PRINT and S_OUT, waiting while the receiver stalls.
// After reset and after each new job request the store is cleared to spaces,
// one word a cycle, and no request is taken until the clear is done.
module card_job_machine_executor
    import cjm_pkg::*;
#(
    parameter int MEM_WORDS  = MEM_WORDS_DEF,
    parameter int CARD_WORDS = CARD_WORDS_DEF
)
(
    input  logic      clk,
    input  logic      rst_n,
    cjm_req_if.sink   req,
    cjm_rsp_if.source rsp
);
    cjm_mem_t    mem;
    logic [31:0] rdata;

    cjm_seq #(.MEM_WORDS(MEM_WORDS), .CARD_WORDS(CARD_WORDS)) u_seq (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp),
        .mem   (mem),
        .rdata (rdata)
    );

    cjm_store #(.MEM_WORDS(MEM_WORDS)) u_store (
        .clk   (clk),
        .mem   (mem),
        .rdata (rdata)
    );
endmodule

/* design/cjm_store.sv */
// ----------------------------------------------------------------------------
// cjm_store
// word store: one synchronous port, registered read data
// ----------------------------------------------------------------------------
module cjm_store
    import cjm_pkg::*;
#(
    parameter int MEM_WORDS = MEM_WORDS_DEF
)
(
    input  logic        clk,
    input  cjm_mem_t    mem,
    output logic [31:0] rdata
);
    localparam int AW = $clog2(MEM_WORDS);

    logic [31:0] mem_reg [MEM_WORDS];

    always_ff @(posedge clk)
    begin
        if (mem.wr)
        begin
            mem_reg[mem.addr[AW-1:0]] <= mem.wdata;
        end
        if (mem.rd)
        begin
            rdata <= mem_reg[mem.addr[AW-1:0]];
        end
    end
endmodule

/* design/cjm_seq.sv */
// ----------------------------------------------------------------------------
// cjm_seq
// request sequencer: read, modify and write back the word store
// ----------------------------------------------------------------------------
module cjm_seq
    import cjm_pkg::*;
#(
    parameter int MEM_WORDS  = MEM_WORDS_DEF,
    parameter int CARD_WORDS = CARD_WORDS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    cjm_req_if.sink     req,
    cjm_rsp_if.source   rsp,
    output cjm_mem_t    mem,
    input  logic [31:0] rdata
);
    localparam int AW = $clog2(MEM_WORDS);
    localparam logic [12:0] ADDR_BIAS = {5'd0, CH_ZERO} * 13'd11;

    typedef enum logic [7:0] {
        S_CLEAR = 8'b0000_0001,
        S_IDLE  = 8'b0000_0010,
        S_BYTE  = 8'b0000_0100,
        S_FETCH = 8'b0000_1000,
        S_DEC   = 8'b0001_0000,
        S_OPND  = 8'b0010_0000,
        S_PRINT = 8'b0100_0000,
        S_OUT   = 8'b1000_0000
    } state_t;

    state_t      state_reg, state_next;
    logic [6:0]  clr_reg, clr_next;
    logic [31:0] r_reg, r_next;
    logic [6:0]  ic_reg, ic_next;
    logic        c_reg, c_next;
    mode_t       mode_reg, mode_next;
    logic [6:0]  lb_reg, lb_next;
    logic [6:0]  cs_reg, cs_next;
    logic [6:0]  fw_reg, fw_next;
    logic [1:0]  fb_reg, fb_next;
    logic [7:0]  ch_reg, ch_next;
    logic [7:0]  op_c0_reg, op_c0_next;
    logic [6:0]  addr_reg, addr_next;
    logic [6:0]  pcnt_reg, pcnt_next;
    logic        ovalid_reg, ovalid_next;
    cjm_rsp_t    odata_reg, odata_next;

    logic        out_free;
    logic        acc;
    logic [7:0]  c0, c1, d2, d3;
    logic [12:0] addr_raw, addr_w;
    logic        addr_ok;
    logic [31:0] byte_mask, byte_val;
    logic [4:0]  sh;

    assign out_free  = !ovalid_reg || rsp.ready;
    assign req.ready = (state_reg == S_IDLE) && out_free;
    assign acc       = req.valid && req.ready;
    assign rsp.valid = ovalid_reg;
    assign rsp.data  = odata_reg;

    assign c0 = rdata[31:24];
    assign c1 = rdata[23:16];
    assign d2 = rdata[15:8];
    assign d3 = rdata[7:0];
    assign addr_raw = ({5'd0, d2} << 3) + ({5'd0, d2} << 1) + {5'd0, d3};
    assign addr_w   = addr_raw - ADDR_BIAS;
    assign addr_ok  = (addr_raw >= ADDR_BIAS) && (addr_raw < ADDR_BIAS + 13'(MEM_WORDS));
    assign sh = 5'((2'd3 - fb_reg) * 4'd8);
    assign byte_mask = 32'hFF << sh;
    assign byte_val  = {24'd0, ch_reg} << sh;

    always_comb
    begin
        state_next  = state_reg;
        clr_next    = clr_reg;
        r_next      = r_reg;
        ic_next     = ic_reg;
        c_next      = c_reg;
        mode_next   = mode_reg;
        lb_next     = lb_reg;
        cs_next     = cs_reg;
        fw_next     = fw_reg;
        fb_next     = fb_reg;
        ch_next     = ch_reg;
        op_c0_next  = op_c0_reg;
        addr_next   = addr_reg;
        pcnt_next   = pcnt_reg;
        ovalid_next = ovalid_reg && !rsp.ready;
        odata_next  = odata_reg;
        mem         = '0;

        case (state_reg)
            S_CLEAR:
            begin
                mem.wr    = 1'b1;
                mem.addr  = clr_reg;
                mem.wdata = SPACE_WORD;
                clr_next  = clr_reg + 7'd1;
                if (clr_reg == 7'(MEM_WORDS - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (acc)
                begin
                    odata_next = '{status: ST_OK, out_word: '0, last: 1'b1,
                                   counter_now: ic_reg, compare_now: c_reg};
                    ovalid_next = 1'b1;
                    case (req.data.operation)
                        OP_NEW_JOB:
                        begin
                            r_next = SPACE_WORD;
                            ic_next = '0;
                            c_next = 1'b0;
                            mode_next = MODE_LOADING;
                            lb_next = '0;
                            cs_next = '0;
                            fw_next = '0;
                            fb_next = '0;
                            clr_next = '0;
                            state_next = S_CLEAR;
                            odata_next.counter_now = '0;
                            odata_next.compare_now = 1'b0;
                        end
                        OP_PROG_BYTE, OP_DATA_BYTE:
                        begin
                            if ((req.data.operation == OP_PROG_BYTE && mode_reg == MODE_LOADING)
                                || (req.data.operation == OP_DATA_BYTE
                                    && mode_reg == MODE_WAITING))
                            begin
                                if (req.data.byte_in != CH_LF && req.data.byte_in != CH_CR
                                    && fw_reg < 7'(CARD_WORDS) + cs_reg
                                    && fw_reg < 7'(MEM_WORDS))
                                begin
                                    ch_next    = req.data.byte_in;
                                    mem.rd     = 1'b1;
                                    mem.addr   = fw_reg;
                                    state_next = S_BYTE;
                                end
                            end
                            else
                            begin
                                odata_next.status = ST_REFUSE;
                            end
                        end
                        OP_PROG_END:
                        begin
                            if (mode_reg == MODE_LOADING)
                            begin
                                lb_next = lb_reg + fw_reg - cs_reg;
                                cs_next = lb_reg + fw_reg - cs_reg;
                                fw_next = lb_reg + fw_reg - cs_reg;
                                fb_next = '0;
                            end
                            else
                            begin
                                odata_next.status = ST_REFUSE;
                            end
                        end
                        OP_DATA_END:
                        begin
                            if (mode_reg == MODE_WAITING)
                            begin
                                mode_next = MODE_RUNNING;
                                cs_next = lb_reg;
                                fw_next = lb_reg;
                                fb_next = '0;
                            end
                            else
                            begin
                                odata_next.status = ST_REFUSE;
                            end
                        end
                        OP_STEP:
                        begin
                            if (mode_reg == MODE_HALTED)
                            begin
                                odata_next.status = ST_HALT;
                            end
                            else if (mode_reg == MODE_WAITING)
                            begin
                                odata_next.status = ST_WAIT;
                            end
                            else if (ic_reg >= 7'(MEM_WORDS))
                            begin
                                mode_next = MODE_HALTED;
                                odata_next.status = ST_ADDR;
                            end
                            else
                            begin
                                mode_next   = MODE_RUNNING;
                                mem.rd      = 1'b1;
                                mem.addr    = ic_reg;
                                ic_next     = ic_reg + 7'd1;
                                ovalid_next = 1'b0;
                                state_next  = S_DEC;
                            end
                        end
                        default:
                        begin
                            odata_next.status = ST_REFUSE;
                        end
                    endcase
                end
            end
            S_BYTE:
            begin
                mem.wr    = 1'b1;
                mem.addr  = fw_reg;
                mem.wdata = (rdata & ~byte_mask) | byte_val;
                fb_next   = fb_reg + 2'd1;
                if (fb_reg == 2'd3)
                begin
                    fw_next = fw_reg + 7'd1;
                end
                state_next = S_IDLE;
            end
            S_DEC:
            begin
                state_next = S_OUT;
                odata_next = '{status: ST_OK, out_word: '0, last: 1'b1,
                               counter_now: ic_reg, compare_now: c_reg};
                addr_next  = addr_w[6:0];
                op_c0_next = c0;
                if (c0 == CH_H)
                begin
                    mode_next = MODE_HALTED;
                    odata_next.status = ST_HALT;
                end
                else if ((c1 == CH_D && (c0 == CH_G || c0 == CH_P))
                    || (c1 == CH_R && (c0 == CH_L || c0 == CH_S || c0 == CH_C))
                    || (c0 == CH_B && c1 == CH_T))
                begin
                    if (!addr_ok || (c0 == CH_P && c1 == CH_D
                        && addr_w + 13'(CARD_WORDS) > 13'(MEM_WORDS)))
                    begin
                        mode_next = MODE_HALTED;
                        odata_next.status = ST_ADDR;
                    end
                    else if (c0 == CH_G)
                    begin
                        mode_next = MODE_WAITING;
                        cs_next = addr_w[6:0];
                        fw_next = addr_w[6:0];
                        fb_next = '0;
                        odata_next.status = ST_WAIT;
                    end
                    else if (c0 == CH_P)
                    begin
                        pcnt_next = '0;
                        state_next = S_PRINT;
                    end
                    else if (c0 == CH_S)
                    begin
                        mem.wr = 1'b1;
                        mem.addr = addr_w[6:0];
                        mem.wdata = r_reg;
                    end
                    else if (c0 == CH_B)
                    begin
                        if (c_reg)
                        begin
                            ic_next = addr_w[6:0];
                            odata_next.counter_now = addr_w[6:0];
                        end
                    end
                    else
                    begin
                        mem.rd = 1'b1;
                        mem.addr = addr_w[6:0];
                        state_next = S_OPND;
                    end
                end
            end
            S_OPND:
            begin
                if (op_c0_reg == CH_L)
                begin
                    r_next = rdata;
                end
                else
                begin
                    c_next = (rdata == r_reg);
                    odata_next.compare_now = (rdata == r_reg);
                end
                state_next = S_OUT;
            end
            S_PRINT:
            begin
                if (out_free)
                begin
                    mem.rd = 1'b1;
                    mem.addr = addr_reg + pcnt_reg;
                    state_next = S_OUT;
                    odata_next.status = ST_WORD;
                end
            end
            S_OUT:
            begin
                if (odata_reg.status == ST_WORD)
                begin
                    odata_next.out_word = rdata;
                    odata_next.last = (pcnt_reg == 7'(CARD_WORDS - 1));
                    ovalid_next = 1'b1;
                    pcnt_next = pcnt_reg + 7'd1;
                    state_next = (pcnt_reg == 7'(CARD_WORDS - 1)) ? S_IDLE : S_PRINT;
                end
                else
                begin
                    ovalid_next = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_CLEAR;
            clr_reg    <= '0;
            r_reg      <= SPACE_WORD;
            ic_reg     <= '0;
            c_reg      <= 1'b0;
            mode_reg   <= MODE_LOADING;
            lb_reg     <= '0;
            cs_reg     <= '0;
            fw_reg     <= '0;
            fb_reg     <= '0;
            ovalid_reg <= 1'b0;
            pcnt_reg   <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            clr_reg    <= clr_next;
            r_reg      <= r_next;
            ic_reg     <= ic_next;
            c_reg      <= c_next;
            mode_reg   <= mode_next;
            lb_reg     <= lb_next;
            cs_reg     <= cs_next;
            fw_reg     <= fw_next;
            fb_reg     <= fb_next;
            ovalid_reg <= ovalid_next;
            pcnt_reg   <= pcnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ch_reg    <= ch_next;
        op_c0_reg <= op_c0_next;
        addr_reg  <= addr_next;
        odata_reg <= odata_next;
    end

    a_fill_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        fw_reg <= 7'(MEM_WORDS))
        else $error("fill pointer beyond store");
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> !req.ready)
        else $error("request taken while busy");
    a_clear_done: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CLEAR && clr_reg == 7'(MEM_WORDS - 1)) |=> (state_reg == S_IDLE))
        else $error("clear pass did not finish");
    a_print_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_PRINT) |-> (pcnt_reg < 7'(CARD_WORDS)))
        else $error("print count overrun");
endmodule
